[src/sprg_pkg.sv]
// shared types and constants for the servo pulse ramp generator
package sprg_pkg;

   localparam int unsigned PulseMin   = 500;
   localparam int unsigned PulseMax   = 2500;
   localparam int unsigned TimeMin    = 20;
   localparam int unsigned TimeMax    = 30000;
   localparam int unsigned PulseReset = 1500;
   localparam int unsigned MoveReset  = 2000;

   // configuration register indexes
   localparam logic [1:0] CSR_SERVO_COUNT = 2'd0;
   localparam logic [1:0] CSR_NARROW_LOW  = 2'd1;
   localparam logic [1:0] CSR_NARROW_HIGH = 2'd2;
   localparam logic [1:0] CSR_WIDE_SERVO  = 2'd3;

   // input action codes
   localparam logic ACT_SET  = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   // classified command passed from front to back
   typedef struct packed {
      logic        tick;
      logic [3:0]  slot;
      logic [11:0] pulse;
      logic [14:0] duration;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_EMIT,
      ST_WAIT
   } state_type;

endpackage

[src/sprg_if.sv]
// valid/ready channel interfaces for request and response transactions
interface sprg_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [3:0]  servo_id;
   logic [11:0] requested_pulse;
   logic [15:0] move_ms;
   modport source (output valid, action, servo_id, requested_pulse, move_ms, input ready);
   modport sink   (input valid, action, servo_id, requested_pulse, move_ms, output ready);
endinterface

interface sprg_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  servo_index;
   logic [11:0] pulse_width;
   logic [11:0] duty_count;
   logic        last;
   modport source (output valid, servo_index, pulse_width, duty_count, last, input ready);
   modport sink   (input valid, servo_index, pulse_width, duty_count, last, output ready);
endinterface

[src/servo_pulse_ramp_generator.sv]
// top level of the servo pulse ramp generator
// A set-target transaction is checked and clamped in the front end and queued;
// a tick runs in the back end. A tick that starts a ramp first runs the serial
// divider once per servo for the increments, then every tick of a ramp takes
// each servo through multiply, clamp and hand-off, plus any output stalls. The
// two-entry queue lets the front take transactions while the back works.
module servo_pulse_ramp_generator #(
   parameter int MAX_SERVOS = 8
) (
   input  logic        clock,
   input  logic        reset,
   sprg_req_if.sink    req,
   sprg_rsp_if.source  rsp,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_write_data
);
   logic [3:0]  servo_count_ff;
   logic [11:0] narrow_low_ff, narrow_high_ff;
   logic [3:0]  wide_servo_ff;
   logic        cmd_valid, cmd_ready;
   sprg_pkg::cmd_type cmd;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         servo_count_ff <= 4'd6;
         narrow_low_ff  <= 12'd900;
         narrow_high_ff <= 12'd2200;
         wide_servo_ff  <= 4'd6;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            sprg_pkg::CSR_SERVO_COUNT: servo_count_ff <= csr_write_data[3:0];
            sprg_pkg::CSR_NARROW_LOW:  narrow_low_ff  <= csr_write_data;
            sprg_pkg::CSR_NARROW_HIGH: narrow_high_ff <= csr_write_data;
            sprg_pkg::CSR_WIDE_SERVO:  wide_servo_ff  <= csr_write_data[3:0];
            default: ;
         endcase
      end
   end

   sprg_front #(.MAX_SERVOS(MAX_SERVOS)) u_front (
      .clock, .reset,
      .servo_count(servo_count_ff), .narrow_low(narrow_low_ff),
      .narrow_high(narrow_high_ff), .wide_servo(wide_servo_ff),
      .req, .cmd_valid, .cmd_ready, .cmd
   );

   sprg_back #(.MAX_SERVOS(MAX_SERVOS)) u_back (
      .clock, .reset, .servo_count(servo_count_ff),
      .cmd_valid, .cmd_ready, .cmd, .rsp
   );
endmodule

[src/sprg_front.sv]
// front end: validates and clamps set-target transactions, passes ticks
module sprg_front #(
   parameter int MAX_SERVOS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [3:0]           servo_count,
   input  logic [11:0]          narrow_low,
   input  logic [11:0]          narrow_high,
   input  logic [3:0]           wide_servo,
   sprg_req_if.sink             req,
   output logic                 cmd_valid,
   input  logic                 cmd_ready,
   output sprg_pkg::cmd_type    cmd
);
   logic [4:0]  used;
   logic        ok;
   logic [11:0] p;
   logic [15:0] t;
   logic [1:0]  cnt_ff, cnt_in;
   sprg_pkg::cmd_type q_ff [2];
   sprg_pkg::cmd_type q_in_cmd;
   logic        wr_ptr_ff, rd_ptr_ff;
   logic        push, pop;

   assign used = ({1'b0, servo_count} > 5'(MAX_SERVOS)) ? 5'(MAX_SERVOS)
                                                        : {1'b0, servo_count};

   // classification and clamping
   always_comb begin
      ok = (req.servo_id != 4'd0) && ({1'b0, req.servo_id} <= used) &&
           (req.requested_pulse >= 12'(sprg_pkg::PulseMin)) &&
           (req.requested_pulse <= 12'(sprg_pkg::PulseMax));
      t = req.move_ms;
      if (t < 16'(sprg_pkg::TimeMin)) t = 16'(sprg_pkg::TimeMin);
      if (t > 16'(sprg_pkg::TimeMax)) t = 16'(sprg_pkg::TimeMax);
      p = req.requested_pulse;
      if (req.servo_id != wide_servo) begin
         if (p > narrow_high) p = narrow_high;
         else if (p < narrow_low) p = narrow_low;
      end
      if (p < 12'(sprg_pkg::PulseMin)) p = 12'(sprg_pkg::PulseMin);
      if (p > 12'(sprg_pkg::PulseMax)) p = 12'(sprg_pkg::PulseMax);
      q_in_cmd.tick     = (req.action == sprg_pkg::ACT_TICK);
      q_in_cmd.slot     = req.servo_id - 4'd1;
      q_in_cmd.pulse    = p;
      q_in_cmd.duration = t[14:0];
   end

   // two-entry queue; rejected set-targets are dropped on entry
   assign req.ready = (cnt_ff != 2'd2);
   assign push = req.valid && req.ready && ((req.action == sprg_pkg::ACT_TICK) || ok);
   assign pop  = cmd_valid && cmd_ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd = q_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= q_in_cmd;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(cnt_ff == 2'd2 && push)) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(cnt_ff == 2'd0 && pop)) else $error("queue underflow");
   a_count: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count out of range");
endmodule

[src/sprg_back.sv]
// back end: ramp state, serial divider, step multiply and result emission
module sprg_back #(
   parameter int MAX_SERVOS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [3:0]           servo_count,
   input  logic                 cmd_valid,
   output logic                 cmd_ready,
   input  sprg_pkg::cmd_type    cmd,
   sprg_rsp_if.source           rsp
);
   localparam int IW = (MAX_SERVOS > 1) ? $clog2(MAX_SERVOS) : 1;

   logic [11:0] target_ff  [MAX_SERVOS];
   logic [11:0] current_ff [MAX_SERVOS];
   logic signed [28:0] inc_ff [MAX_SERVOS];
   logic [14:0] dur_ff;
   logic        pend_ff;
   logic [10:0] steps_ff;
   logic        active_ff;

   sprg_pkg::state_type st_ff, st_in;
   logic [IW:0]  idx_ff, idx_in;
   logic [4:0]   n;
   // divider
   logic [4:0]   dcnt_ff, dcnt_in;
   logic [28:0]  quo_ff, quo_in;
   logic [11:0]  rem_ff, rem_in;
   logic         neg_ff, neg_in;
   // multiply result
   logic signed [40:0] prod_ff, prod_in;
   logic [11:0]  pw_ff, pw_in;
   logic [11:0]  out_p;
   logic signed [41:0] v;
   logic [11:0]  cur, tgt;
   logic [11:0]  mag;
   logic [12:0]  trial;
   logic [27:0]  dur_prod;
   logic [10:0]  dur_steps;
   logic [10:0]  newsteps;
   logic [29:0]  duty_prod;
   logic         emit_done;

   assign n = ({1'b0, servo_count} > 5'(MAX_SERVOS)) ? 5'(MAX_SERVOS) : {1'b0, servo_count};
   assign cur = current_ff[idx_ff[IW-1:0]];
   assign tgt = target_ff[idx_ff[IW-1:0]];
   assign mag = (cur >= tgt) ? (cur - tgt) : (tgt - cur);
   // duration/20 as (duration>>2)*ceil(2^16/5)>>16, exact for durations below 2^16
   assign dur_prod  = 28'(dur_ff[14:2]) * 28'd13108;
   assign dur_steps = dur_prod[26:16];
   assign newsteps = (dur_steps == 11'd0) ? 11'd1 : dur_steps;
   // divider works against steps+1 during setup, because steps_ff already holds remaining
   assign trial = {rem_ff, quo_ff[28]} - {2'b00, steps_ff + 11'd1};
   assign v = 42'(signed'({30'd0, tgt})) + 42'(prod_ff / 41'sd65536);
   assign out_p = (steps_ff == 11'd0) ? tgt :
                  (v < 42'sd500) ? 12'd500 : (v > 42'sd2500) ? 12'd2500 : v[11:0];
   assign emit_done = ({1'b0, idx_ff} + 5'd1 >= n);

   // duty count pulse*32/25 via reciprocal multiply by ceil(2^22/25)
   assign duty_prod = 30'(pw_ff) * 30'd167773;

   assign cmd_ready = (st_ff == sprg_pkg::ST_IDLE) && !rsp.valid;
   assign rsp.valid = (st_ff == sprg_pkg::ST_WAIT);
   assign rsp.servo_index = 3'(idx_ff);
   assign rsp.pulse_width = pw_ff;
   assign rsp.duty_count  = duty_prod[28:17];
   assign rsp.last = emit_done;

   // sequencer
   always_comb begin
      st_in = st_ff; idx_in = idx_ff;
      dcnt_in = dcnt_ff; quo_in = quo_ff; rem_in = rem_ff; neg_in = neg_ff;
      prod_in = prod_ff; pw_in = pw_ff;
      unique case (st_ff)
         sprg_pkg::ST_IDLE: begin
            if (cmd_valid && cmd.tick && (pend_ff || active_ff)) begin
               idx_in = '0;
               st_in = (n == 5'd0) ? sprg_pkg::ST_IDLE :
                       (pend_ff ? sprg_pkg::ST_DIV : sprg_pkg::ST_MUL);
               dcnt_in = 5'd0; quo_in = '0; rem_in = '0;
            end
         end
         sprg_pkg::ST_DIV: begin
            // restoring division of |diff|<<16 by steps, one bit a cycle
            if (dcnt_ff == 5'd0) begin
               quo_in = {1'b0, mag, 16'd0};
               rem_in = '0;
               neg_in = cur < tgt;
               dcnt_in = 5'd1;
            end else begin
               if (!trial[12]) begin
                  rem_in = trial[11:0];
                  quo_in = {quo_ff[27:0], 1'b1};
               end else begin
                  rem_in = {rem_ff[10:0], quo_ff[28]};
                  quo_in = {quo_ff[27:0], 1'b0};
               end
               dcnt_in = dcnt_ff + 5'd1;
               if (dcnt_ff == 5'd29) begin
                  dcnt_in = 5'd0;
                  if (emit_done) begin
                     idx_in = '0;
                     st_in = sprg_pkg::ST_MUL;
                  end else idx_in = idx_ff + 1'b1;
               end
            end
         end
         sprg_pkg::ST_MUL: begin
            prod_in = 41'(inc_ff[idx_ff[IW-1:0]]) * 41'(signed'({1'b0, steps_ff}));
            st_in = sprg_pkg::ST_EMIT;
         end
         sprg_pkg::ST_EMIT: begin
            pw_in = out_p;
            st_in = sprg_pkg::ST_WAIT;
         end
         sprg_pkg::ST_WAIT: begin
            if (rsp.ready) begin
               if (emit_done) st_in = sprg_pkg::ST_IDLE;
               else begin
                  idx_in = idx_ff + 1'b1;
                  st_in = sprg_pkg::ST_MUL;
               end
            end
         end
         default: st_in = sprg_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= sprg_pkg::ST_IDLE;
         idx_ff <= '0;
         dcnt_ff <= 5'd0;
         pend_ff <= 1'b0;
         active_ff <= 1'b0;
         steps_ff <= 11'd0;
         dur_ff <= 15'(sprg_pkg::MoveReset);
         for (int i = 0; i < MAX_SERVOS; i++) begin
            target_ff[i]  <= 12'(sprg_pkg::PulseReset);
            current_ff[i] <= 12'(sprg_pkg::PulseReset);
            inc_ff[i]     <= '0;
         end
      end else begin
         st_ff <= st_in; idx_ff <= idx_in;
         dcnt_ff <= dcnt_in;
         // set target transactions
         if (cmd_valid && cmd_ready && !cmd.tick) begin
            target_ff[cmd.slot[IW-1:0]] <= cmd.pulse;
            dur_ff <= cmd.duration;
            pend_ff <= 1'b1;
         end
         // tick start: ramp bookkeeping
         if (cmd_valid && cmd_ready && cmd.tick && (pend_ff || active_ff)) begin
            if (pend_ff) begin
               pend_ff <= 1'b0;
               active_ff <= (newsteps != 11'd1);
               steps_ff <= newsteps - 11'd1;
            end else begin
               if (steps_ff != 11'd0) steps_ff <= steps_ff - 11'd1;
               if (steps_ff <= 11'd1) active_ff <= 1'b0;
            end
         end
         if (st_ff == sprg_pkg::ST_DIV && dcnt_ff == 5'd29)
            inc_ff[idx_ff[IW-1:0]] <= neg_ff ? -signed'(quo_in) : signed'(quo_in);
         if (st_ff == sprg_pkg::ST_EMIT)
            current_ff[idx_ff[IW-1:0]] <= out_p;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in; rem_ff <= rem_in; neg_ff <= neg_in;
      prod_ff <= prod_in; pw_ff <= pw_in;
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_ready |-> (st_ff == sprg_pkg::ST_IDLE)) else $error("ready outside idle");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(pw_ff)) else $error("result lost");
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> ({1'b0, idx_ff} < n)) else $error("index out of range");
endmodule

[bench/servo_pulse_ramp_generator_test.sv]
// self-checking testbench for the servo pulse ramp generator
module servo_pulse_ramp_generator_test;

   localparam int NumServos  = 8;
   localparam int IdleLimit  = 5000;
   localparam int DrainCycles = 400;

   typedef struct {
      logic [2:0]  servo_index;
      logic [11:0] pulse_width;
      logic [11:0] duty_count;
      logic        last;
   } pulse_update_type;

   // ramp predictor and store of pending pulse updates
   class ramp_scoreboard;
      int unsigned      servo_count, narrow_low, narrow_high, wide_servo;
      int unsigned      target_pulse [NumServos];
      int unsigned      current_pulse [NumServos];
      longint           step_increment [NumServos];
      int unsigned      move_duration, steps_left;
      bit               change_pending, ramp_active;
      pulse_update_type pending_updates [$];
      int               errors;

      function new();
         servo_count = 6; narrow_low = 900; narrow_high = 2200; wide_servo = 6;
         for (int i = 0; i < NumServos; i++) begin
            target_pulse[i] = sprg_pkg::PulseReset;
            current_pulse[i] = sprg_pkg::PulseReset;
            step_increment[i] = 0;
         end
         move_duration = sprg_pkg::MoveReset;
         change_pending = 0; steps_left = 0; ramp_active = 0; errors = 0;
      endfunction

      function void write_register(logic [1:0] index, logic [11:0] value);
         case (index)
            sprg_pkg::CSR_SERVO_COUNT: servo_count = value[3:0];
            sprg_pkg::CSR_NARROW_LOW:  narrow_low  = value;
            sprg_pkg::CSR_NARROW_HIGH: narrow_high = value;
            sprg_pkg::CSR_WIDE_SERVO:  wide_servo  = value[3:0];
            default: ;
         endcase
      endfunction

      // predict the updates caused by one accepted request transaction
      function void note_request(logic action, logic [3:0] id, logic [11:0] pulse,
                                 logic [15:0] duration);
         int unsigned      used, p, t;
         longint           diff, v;
         pulse_update_type upd;
         used = (servo_count > NumServos) ? NumServos : servo_count;
         if (action == sprg_pkg::ACT_SET) begin
            p = pulse; t = duration;
            if (id == 0 || id > used || p < sprg_pkg::PulseMin || p > sprg_pkg::PulseMax)
               return;
            if (t < sprg_pkg::TimeMin) t = sprg_pkg::TimeMin;
            if (t > sprg_pkg::TimeMax) t = sprg_pkg::TimeMax;
            if (id != wide_servo) begin
               if (p > narrow_high) p = narrow_high;
               else if (p < narrow_low) p = narrow_low;
            end
            if (p < sprg_pkg::PulseMin) p = sprg_pkg::PulseMin;
            if (p > sprg_pkg::PulseMax) p = sprg_pkg::PulseMax;
            target_pulse[id-1] = p;
            move_duration = t;
            change_pending = 1;
            return;
         end
         // ramp start on a tick with a pending change
         if (change_pending) begin
            change_pending = 0;
            steps_left = move_duration / 20;
            if (steps_left == 0) steps_left = 1;
            for (int i = 0; i < used; i++) begin
               diff = longint'(current_pulse[i]) - longint'(target_pulse[i]);
               step_increment[i] = (diff * 65536) / longint'(steps_left);
            end
            ramp_active = 1;
         end
         if (!ramp_active) return;
         if (steps_left > 0) steps_left--;
         for (int i = 0; i < used; i++) begin
            if (steps_left == 0) begin
               p = target_pulse[i];
            end else begin
               v = longint'(target_pulse[i]) +
                   (step_increment[i] * longint'(steps_left)) / 65536;
               if (v < longint'(sprg_pkg::PulseMin)) v = sprg_pkg::PulseMin;
               if (v > longint'(sprg_pkg::PulseMax)) v = sprg_pkg::PulseMax;
               p = 32'(v);
            end
            current_pulse[i] = p;
            upd.servo_index = 3'(i);
            upd.pulse_width = 12'(p);
            upd.duty_count  = 12'((p * 32) / 25);
            upd.last        = (i + 1 == used);
            pending_updates.push_back(upd);
         end
         if (steps_left == 0) ramp_active = 0;
      endfunction

      // compare one accepted response transaction with the oldest prediction
      function void check_response(logic [2:0] idx, logic [11:0] pw, logic [11:0] dc,
                                   logic lst);
         pulse_update_type want;
         if (pending_updates.size() == 0) begin
            $error("unexpected response: servo_index %0d pulse_width %0d", idx, pw);
            errors++;
            return;
         end
         want = pending_updates.pop_front();
         if (idx !== want.servo_index) begin
            $error("servo_index expected %0d actual %0d", want.servo_index, idx);
            errors++;
         end
         if (pw !== want.pulse_width) begin
            $error("pulse_width expected %0d actual %0d", want.pulse_width, pw);
            errors++;
         end
         if (dc !== want.duty_count) begin
            $error("duty_count expected %0d actual %0d", want.duty_count, dc);
            errors++;
         end
         if (lst !== want.last) begin
            $error("last expected %0d actual %0d", want.last, lst);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_write_enable = 0;
   logic [1:0]  csr_index = sprg_pkg::CSR_SERVO_COUNT;
   logic [11:0] csr_write_data = '0;
   int          idle_cycles = 0;
   ramp_scoreboard ramp_sb = new();

   sprg_req_if req ();
   sprg_rsp_if rsp ();

   servo_pulse_ramp_generator i_dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req),
      .rsp              (rsp),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   initial begin
      req.valid = 0;
      req.action = sprg_pkg::ACT_TICK;
      req.servo_id = '0;
      req.requested_pulse = '0;
      req.move_ms = '0;
      rsp.ready = 0;
   end

   // watchdog on cycles with no transaction
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_cycles <= 0;
      end else if (!reset) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // response side with random stalls
   initial begin
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp.ready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1;
         do @(posedge clock); while (!rsp.valid);
         ramp_sb.check_response(rsp.servo_index, rsp.pulse_width, rsp.duty_count,
                                rsp.last);
      end
   end

   // send one request transaction after a random gap
   task automatic send_request(logic action, logic [3:0] id, logic [11:0] pulse,
                               logic [15:0] duration);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1;
      req.action <= action;
      req.servo_id <= id;
      req.requested_pulse <= pulse;
      req.move_ms <= duration;
      do @(posedge clock); while (!req.ready);
      ramp_sb.note_request(action, id, pulse, duration);
   endtask

   task automatic send_tick();
      send_request(sprg_pkg::ACT_TICK, 4'($urandom), 12'($urandom), 16'($urandom));
   endtask

   // let all pending work finish before touching registers
   task automatic wait_quiet();
      req.valid <= 0;
      @(posedge clock);
      while (ramp_sb.pending_updates.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // enable is left high; the caller drops it after the last write
   task automatic write_csr(logic [1:0] index, logic [11:0] value);
      csr_write_enable <= 1;
      csr_index <= index;
      csr_write_data <= value;
      @(posedge clock);
      ramp_sb.write_register(index, value);
   endtask

   task automatic configure(int unsigned count, int unsigned lo, int unsigned hi,
                            int unsigned wide);
      wait_quiet();
      write_csr(sprg_pkg::CSR_SERVO_COUNT, {8'($urandom), 4'(count)});
      write_csr(sprg_pkg::CSR_NARROW_LOW, 12'(lo));
      write_csr(sprg_pkg::CSR_NARROW_HIGH, 12'(hi));
      write_csr(sprg_pkg::CSR_WIDE_SERVO, {8'($urandom), 4'(wide)});
      csr_write_enable <= 0;
   endtask

   // random mix, mostly valid set targets with short moves and ticks
   task automatic random_phase(int items);
      int           kind;
      logic [15:0]  duration;
      for (int n = 0; n < items; n++) begin
         kind = $urandom_range(0, 99);
         duration = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(0, 300));
         if (kind < 45) send_tick();
         else if (kind < 85)
            send_request(sprg_pkg::ACT_SET, 4'($urandom_range(1, 8)),
                         12'($urandom_range(sprg_pkg::PulseMin, sprg_pkg::PulseMax)),
                         duration);
         else
            send_request(sprg_pkg::ACT_SET, 4'($urandom), 12'($urandom), 16'($urandom));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: defaults, rejections, clamps, single-step and restarted ramps
      send_tick();
      send_request(sprg_pkg::ACT_SET, 4'd1, 12'(sprg_pkg::PulseMin), 16'd0);
      send_request(sprg_pkg::ACT_SET, 4'd6, 12'(sprg_pkg::PulseMax), 16'hffff);
      send_request(sprg_pkg::ACT_SET, 4'd2, 12'd499, 16'd40);
      send_request(sprg_pkg::ACT_SET, 4'd3, 12'd2501, 16'd40);
      send_request(sprg_pkg::ACT_SET, 4'd0, 12'd1000, 16'd40);
      send_request(sprg_pkg::ACT_SET, 4'd7, 12'd1000, 16'd40);
      send_request(sprg_pkg::ACT_SET, 4'd4, 12'hfff, 16'd40);
      send_request(sprg_pkg::ACT_SET, 4'd5, 12'(sprg_pkg::PulseMax), 16'd19);
      send_tick();
      send_tick();
      send_request(sprg_pkg::ACT_SET, 4'd2, 12'(sprg_pkg::PulseMin), 16'd100);
      send_tick();
      send_tick();
      send_request(sprg_pkg::ACT_SET, 4'd3, 12'd2000, 16'd60);
      send_tick();
      repeat (5) send_tick();
      send_request(sprg_pkg::ACT_SET, 4'd6, 12'(sprg_pkg::PulseMin), 16'd20);
      send_tick();
      send_tick();
      random_phase(60);

      configure(8, 500, 2500, 0);
      send_request(sprg_pkg::ACT_SET, 4'd8, 12'(sprg_pkg::PulseMax), 16'd30000);
      send_request(sprg_pkg::ACT_SET, 4'd1, 12'(sprg_pkg::PulseMin), 16'd30001);
      repeat (3) send_tick();
      send_request(sprg_pkg::ACT_SET, 4'd8, 12'd1500, 16'd20);
      send_tick();
      random_phase(40);

      configure(15, 0, 4095, 8);
      random_phase(60);

      configure(1, 2500, 500, 1);
      random_phase(50);

      configure(3, 1000, 2000, 15);
      random_phase(60);

      // zero servos: ramp still counts down with no output
      send_request(sprg_pkg::ACT_SET, 4'd2, 12'd1200, 16'd200);
      send_tick();
      configure(0, 900, 2200, 6);
      random_phase(30);

      configure(6, 900, 2200, 6);
      random_phase(40);

      wait_quiet();
      if (ramp_sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[sim.f]
src/sprg_pkg.sv
src/sprg_if.sv
src/sprg_front.sv
src/sprg_back.sv
src/servo_pulse_ramp_generator.sv
bench/servo_pulse_ramp_generator_test.sv
